>>> sv/adagrad_pkg.sv
// Types, constants and fp32 arithmetic helpers for the Adagrad update pipeline.
package adagrad_pkg;

   localparam logic [31:0] QNAN      = 32'h7FC0_0000;
   localparam logic [30:0] INF_MAG   = 31'h7F80_0000;
   localparam logic [31:0] SIGN_MASK = 32'h8000_0000;

   localparam logic [1:0] CSR_LEARNING_RATE = 2'd0;
   localparam logic [1:0] CSR_EPSILON       = 2'd1;
   localparam logic [1:0] CSR_DECAY_FACTOR  = 2'd2;

   localparam logic [31:0] LEARNING_RATE_RST = 32'h3C23_D70A;
   localparam logic [31:0] EPSILON_RST       = 32'h322B_CC77;
   localparam logic [31:0] DECAY_FACTOR_RST  = 32'h0000_0000;

   typedef struct packed {
      logic [31:0] param_in;
      logic [31:0] grad_in;
      logic [31:0] sq_sum_in;
      logic        is_last;
   } adagrad_req_type;

   typedef struct packed {
      logic [31:0] param_out;
      logic [31:0] update_out;
      logic [31:0] sq_sum_out;
      logic        last_out;
   } adagrad_rsp_type;

   // unpacked operand: value = man * 2^(ex - 23), man normalized
   typedef struct packed {
      logic              nan;
      logic              inf;
      logic              zero;
      logic              sign;
      logic signed [9:0] ex;
      logic [23:0]       man;
   } unp_type;

   // unrounded result: value = man * 2^(ex - 49)
   typedef struct packed {
      logic               nan;
      logic               inf;
      logic               zero;
      logic               sign;
      logic signed [11:0] ex;
      logic [49:0]        man;
   } pre_type;

   typedef struct packed {
      logic              sp;
      logic [31:0]       spv;
      logic signed [9:0] eh;
      logic [49:0]       num;
      logic [25:0]       rem;
      logic [24:0]       root;
   } sqs_type;

   typedef struct packed {
      logic               nan;
      logic               inf;
      logic               zero;
      logic               sign;
      logic signed [11:0] ex;
      logic [24:0]        rem;
      logic [23:0]        dm;
      logic [26:0]        quo;
   } dvs_type;

   typedef struct packed {
      logic [31:0] p;
      logic [31:0] g;
      logic [31:0] s;
      logic [31:0] ssum;
      logic [31:0] upd;
      logic        last;
   } cr_type;

   function automatic logic [5:0] lzc50(input logic [49:0] v);
      logic [5:0] n;
      n = 6'd50;
      for (int i = 0; i < 50; i++) begin
         if (v[i]) n = 6'(49 - i);
      end
      return n;
   endfunction

   function automatic unp_type fp_unpack(input logic [31:0] b);
      unp_type    u;
      logic [5:0] lz;
      logic [23:0] f;
      f      = {1'b0, b[22:0]};
      lz     = lzc50({f, 26'd0});
      u.sign = b[31];
      u.nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
      u.inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
      u.zero = (b[30:0] == 31'd0);
      if (b[30:23] == 8'd0) begin
         u.man = f << lz;
         u.ex  = 10'(-126 - int'(lz));
      end else begin
         u.man = {1'b1, b[22:0]};
         u.ex  = 10'(int'(b[30:23]) - 127);
      end
      if (u.zero) begin
         u.man = 24'd0;
         u.ex  = -10'sd256;
      end
      return u;
   endfunction

   function automatic pre_type fp_mul_pre(input unp_type a, input unp_type b);
      pre_type     r;
      logic [47:0] prod;
      prod   = a.man * b.man;
      r.sign = a.sign ^ b.sign;
      r.nan  = a.nan | b.nan | (a.inf & b.zero) | (a.zero & b.inf);
      r.inf  = a.inf | b.inf;
      r.zero = a.zero | b.zero;
      r.man  = {prod, 2'b00};
      r.ex   = 12'(int'(a.ex) + int'(b.ex) + 1);
      return r;
   endfunction

   function automatic pre_type fp_add_pre(input unp_type a, input unp_type b);
      pre_type     r;
      unp_type     x;
      unp_type     y;
      logic        swap;
      logic [10:0] d;
      logic [49:0] mx;
      logic [49:0] my;
      logic [49:0] sh;
      swap = (b.ex > a.ex) || ((b.ex == a.ex) && (b.man > a.man));
      x    = swap ? b : a;
      y    = swap ? a : b;
      d    = 11'(int'(x.ex) - int'(y.ex));
      mx   = {1'b0, x.man, 25'd0};
      my   = {1'b0, y.man, 25'd0};
      if (d >= 11'd50) begin
         sh = {49'd0, |y.man};
      end else begin
         sh = my >> d;
         if ((sh << d) != my) sh[0] = 1'b1;
      end
      r.man  = (x.sign == y.sign) ? mx + sh : mx - sh;
      r.ex   = 12'(int'(x.ex) + 1);
      r.sign = x.sign;
      r.nan  = a.nan | b.nan | (a.inf & b.inf & (a.sign != b.sign));
      r.inf  = a.inf | b.inf;
      if (a.inf) begin
         r.sign = a.sign;
      end else if (b.inf) begin
         r.sign = b.sign;
      end
      r.zero = 1'b0;
      if (a.zero && b.zero) begin
         r.zero = 1'b1;
         r.sign = a.sign & b.sign;
      end else if (r.man == 50'd0) begin
         r.zero = 1'b1;
         r.sign = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [31:0] fp_round(input pre_type r);
      logic [5:0]         lz;
      logic [5:0]         sh;
      logic signed [11:0] en;
      logic [49:0]        mn;
      logic [49:0]        mt;
      logic [7:0]         be;
      logic               lost;
      logic               inc;
      logic [30:0]        mag;
      int                 shv;
      if (r.nan) return QNAN;
      if (r.inf) return {r.sign, INF_MAG};
      if (r.zero) return {r.sign, 31'd0};
      lz = lzc50(r.man);
      mn = r.man << lz;
      en = 12'(int'(r.ex) - int'(lz));
      if (en > 12'sd127) return {r.sign, INF_MAG};
      if (en < -12'sd126) begin
         shv = -126 - int'(en);
         sh  = (shv > 63) ? 6'd63 : 6'(shv);
         be  = 8'd0;
      end else begin
         sh = 6'd0;
         be = 8'(int'(en) + 127);
      end
      mt   = mn >> sh;
      lost = (mt << sh) != mn;
      inc  = mt[25] & ((|mt[24:0]) | lost | mt[26]);
      mag  = {be, mt[48:26]} + 31'(inc);
      return {r.sign, mag};
   endfunction

   function automatic sqs_type sqrt_prep(input logic [31:0] b);
      sqs_type     s;
      unp_type     u;
      logic [24:0] m25;
      int          e;
      u      = fp_unpack(b);
      s.sp   = 1'b1;
      s.spv  = b;
      s.rem  = 26'd0;
      s.root = 25'd0;
      if (u.nan) begin
         s.spv = QNAN;
      end else if (u.zero) begin
         s.spv = b;
      end else if (u.sign) begin
         s.spv = QNAN;
      end else if (u.inf) begin
         s.spv = b;
      end else begin
         s.sp = 1'b0;
      end
      e = int'(u.ex);
      if (u.ex[0]) begin
         m25 = {u.man, 1'b0};
         e   = e - 1;
      end else begin
         m25 = {1'b0, u.man};
      end
      s.eh  = 10'(e >>> 1);
      s.num = {m25, 25'd0};
      return s;
   endfunction

   function automatic sqs_type sqrt_step(input sqs_type s);
      sqs_type     r;
      logic [27:0] t;
      logic [27:0] tr;
      r  = s;
      t  = {s.rem, s.num[49:48]};
      tr = {1'b0, s.root, 2'b01};
      if (t >= tr) begin
         r.rem  = 26'(t - tr);
         r.root = {s.root[23:0], 1'b1};
      end else begin
         r.rem  = 26'(t);
         r.root = {s.root[23:0], 1'b0};
      end
      r.num = {s.num[47:0], 2'b00};
      return r;
   endfunction

   function automatic logic [31:0] sqrt_fin(input sqs_type s);
      logic [23:0] q;
      logic        inc;
      logic [30:0] mag;
      if (s.sp) return s.spv;
      q   = s.root[24:1];
      inc = s.root[0] & ((s.rem != 26'd0) | q[0]);
      mag = {8'(int'(s.eh) + 127), q[22:0]} + 31'(inc);
      return {1'b0, mag};
   endfunction

   function automatic dvs_type div_prep(input unp_type n, input unp_type d);
      dvs_type r;
      r.sign = n.sign ^ d.sign;
      r.nan  = 1'b0;
      r.inf  = 1'b0;
      r.zero = 1'b0;
      if (d.zero) begin
         r.nan = n.nan | n.zero;
         r.inf = 1'b1;
      end else if (n.nan || d.nan || (n.inf && d.inf)) begin
         r.nan = 1'b1;
      end else if (n.inf) begin
         r.inf = 1'b1;
      end else if (d.inf || n.zero) begin
         r.zero = 1'b1;
      end
      r.rem = {1'b0, n.man};
      r.dm  = d.man;
      r.ex  = 12'(int'(n.ex) - int'(d.ex));
      r.quo = 27'd0;
      return r;
   endfunction

   function automatic dvs_type div_step(input dvs_type s);
      dvs_type     r;
      logic        ge;
      logic [24:0] r1;
      r     = s;
      ge    = s.rem >= {1'b0, s.dm};
      r1    = ge ? s.rem - {1'b0, s.dm} : s.rem;
      r.quo = {s.quo[25:0], ge};
      r.rem = {r1[23:0], 1'b0};
      return r;
   endfunction

   function automatic pre_type div_pre(input dvs_type s);
      pre_type r;
      r.nan  = s.nan;
      r.inf  = s.inf;
      r.zero = s.zero;
      r.sign = s.sign;
      r.ex   = s.ex;
      r.man  = {s.quo, 22'd0, s.rem != 25'd0};
      return r;
   endfunction

endpackage

>>> sv/adagrad_param_update_top.sv
// Adagrad fp32 parameter update: configuration registers, arithmetic pipeline, skid buffer.
//
//   port group   direction  handshake          payload
//   req_*        in         req_valid/ready    adagrad_req_type (param, grad, sum, last)
//   rsp_*        out        rsp_valid/ready    adagrad_rsp_type (param, update, sum, last)
//   csr_*        in         csr_wr_en          csr_index, csr_wdata
//
// One word enters per cycle while req_ready is high; each accepted word reaches rsp_valid through the output buffer.
// The pipeline depth is dominated by the 25-stage square root and 27-stage divider chains.
// Reset clears valid bits, buffer pointers and loads default register values.
// The pipeline holds whenever the two-word output buffer is full; req_ready
// stays high while one finished word waits.
module adagrad_param_update_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  adagrad_pkg::adagrad_req_type  req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output adagrad_pkg::adagrad_rsp_type  rsp_data,
   input  logic                          csr_wr_en,
   input  logic [1:0]                    csr_index,
   input  logic [31:0]                   csr_wdata
);
   import adagrad_pkg::*;

   localparam int NST = 71;

   logic [31:0] lr_ff;
   logic [31:0] eps_ff;
   logic [31:0] wd_ff;
   logic        dec;
   logic        en;
   logic        push;
   logic        pop;

   logic [NST-1:0] vld_ff;
   cr_type         cr_ff [1:NST];
   cr_type         cr8_in;
   cr_type         cr69_in;

   pre_type     pm1_ff;
   logic [31:0] a2_ff;
   pre_type     pa3_ff;
   logic [31:0] gd4_ff;
   pre_type     pm5_ff;
   logic [31:0] sq6_ff;
   pre_type     pa7_ff;
   sqs_type     sqs_ff [0:25];
   logic [31:0] rt35_ff;
   pre_type     pa36_ff;
   logic [31:0] den37_ff;
   dvs_type     dvs_ff [0:27];
   pre_type     pd66_ff;
   logic [31:0] q67_ff;
   pre_type     pm68_ff;
   pre_type     pa70_ff;
   logic [31:0] pn71_ff;

   adagrad_rsp_type ob_ff [0:1];
   logic            wp_ff;
   logic            rp_ff;
   logic [1:0]      cnt_ff;
   logic [1:0]      cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff  <= LEARNING_RATE_RST;
         eps_ff <= EPSILON_RST;
         wd_ff  <= DECAY_FACTOR_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_LEARNING_RATE: lr_ff  <= csr_wdata;
            CSR_EPSILON:       eps_ff <= csr_wdata;
            CSR_DECAY_FACTOR:  wd_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign dec = !wd_ff[31] && (wd_ff[30:0] != 31'd0)
                && !((wd_ff[30:23] == 8'hFF) && (wd_ff[22:0] != 23'd0));

   assign en        = (cnt_ff != 2'd2);
   assign req_ready = en;
   assign push      = en && vld_ff[NST-1];
   assign pop       = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], req_valid};
      end
   end

   always_comb begin
      cr8_in       = cr_ff[7];
      cr8_in.ssum  = fp_round(pa7_ff);
      cr69_in      = cr_ff[68];
      cr69_in.upd  = fp_round(pm68_ff);
   end

   // advance all stages together
   always_ff @(posedge clock) begin
      if (en) begin
         cr_ff[1].p    <= req_data.param_in;
         cr_ff[1].g    <= req_data.grad_in;
         cr_ff[1].s    <= req_data.sq_sum_in;
         cr_ff[1].ssum <= 32'd0;
         cr_ff[1].upd  <= 32'd0;
         cr_ff[1].last <= req_data.is_last;
         for (int i = 2; i <= NST; i++) begin
            if (i == 8) begin
               cr_ff[i] <= cr8_in;
            end else if (i == 69) begin
               cr_ff[i] <= cr69_in;
            end else begin
               cr_ff[i] <= cr_ff[i-1];
            end
         end
         pm1_ff      <= fp_mul_pre(fp_unpack(req_data.param_in), fp_unpack(wd_ff));
         a2_ff       <= fp_round(pm1_ff);
         pa3_ff      <= fp_add_pre(fp_unpack(a2_ff), fp_unpack(cr_ff[2].g));
         gd4_ff      <= dec ? fp_round(pa3_ff) : cr_ff[3].g;
         pm5_ff      <= fp_mul_pre(fp_unpack(gd4_ff), fp_unpack(gd4_ff));
         sq6_ff      <= fp_round(pm5_ff);
         pa7_ff      <= fp_add_pre(fp_unpack(cr_ff[6].s), fp_unpack(sq6_ff));
         sqs_ff[0]   <= sqrt_prep(cr_ff[8].ssum);
         for (int k = 0; k < 25; k++) begin
            sqs_ff[k+1] <= sqrt_step(sqs_ff[k]);
         end
         rt35_ff     <= sqrt_fin(sqs_ff[25]);
         pa36_ff     <= fp_add_pre(fp_unpack(rt35_ff), fp_unpack(eps_ff));
         den37_ff    <= fp_round(pa36_ff);
         dvs_ff[0]   <= div_prep(fp_unpack(cr_ff[37].g), fp_unpack(den37_ff));
         for (int k = 0; k < 27; k++) begin
            dvs_ff[k+1] <= div_step(dvs_ff[k]);
         end
         pd66_ff     <= div_pre(dvs_ff[27]);
         q67_ff      <= fp_round(pd66_ff);
         pm68_ff     <= fp_mul_pre(fp_unpack(q67_ff), fp_unpack(lr_ff ^ SIGN_MASK));
         pa70_ff     <= fp_add_pre(fp_unpack(cr_ff[69].upd), fp_unpack(cr_ff[69].p));
         pn71_ff     <= fp_round(pa70_ff);
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ob_ff[wp_ff].param_out  <= pn71_ff;
         ob_ff[wp_ff].update_out <= cr_ff[NST].upd;
         ob_ff[wp_ff].sq_sum_out <= cr_ff[NST].ssum;
         ob_ff[wp_ff].last_out   <= cr_ff[NST].last;
      end
   end

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = ob_ff[rp_ff];

   a_cnt_range: assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("output buffer fill level out of range");
   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2) |-> !req_ready)
      else $error("input taken while output buffer full");
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved while held");
   a_fill: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (cnt_ff == $past(cnt_ff) + 2'd1))
      else $error("pushed word not counted");

endmodule
